FILE: hw/rtl/clqd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clqd_pkg
// request codes, status codes and cell commands shared by the deque core
// ----------------------------------------------------------------------------
package clqd_pkg;

  // request codes
  localparam logic [2:0] REQ_PUSH      = 3'd0;
  localparam logic [2:0] REQ_POP_FRONT = 3'd1;
  localparam logic [2:0] REQ_POP_BACK  = 3'd2;
  localparam logic [2:0] REQ_POP_COUNT = 3'd3;
  localparam logic [2:0] REQ_POP_QTY   = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_OVER_CAP  = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_EMPTY     = 3'd3;
  localparam logic [2:0] ST_COUNT_BIG = 3'd4;
  localparam logic [2:0] ST_QTY_BIG   = 3'd5;
  localparam logic [2:0] ST_NO_SLOT   = 3'd6;

  // register indexes
  localparam logic REG_CAPACITY  = 1'b0;
  localparam logic REG_TOLERANCE = 1'b1;

  // most result items one request may produce
  localparam int MAX_RESULTS = 16;

  // command broadcast to every cell of the chain
  typedef enum logic [2:0] {
    CELL_HOLD  = 3'd0,
    CELL_CMP   = 3'd1,
    CELL_SHIFT = 3'd2,
    CELL_PUSH  = 3'd3,
    CELL_TRIM  = 3'd4
  } cell_op_t;

endpackage

FILE: hw/rtl/clqd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clqd_cell
// one deque slot: holds an entry, shifts toward the front, compares ids
// ----------------------------------------------------------------------------
module clqd_cell import clqd_pkg::*; #(
  parameter int IDX         = 0,
  parameter int DEPTH       = 16,
  parameter int ID_BITS     = 16,
  parameter int AMOUNT_BITS = 32,
  localparam int CNTW       = $clog2(DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cell_op_t               op,
  input  logic [ID_BITS-1:0]     cmd_id,
  input  logic [AMOUNT_BITS-1:0] cmd_amount,
  input  logic [CNTW-1:0]        count,
  input  logic [ID_BITS-1:0]     next_id,
  input  logic [AMOUNT_BITS-1:0] next_amount,
  output logic [ID_BITS-1:0]     id,
  output logic [AMOUNT_BITS-1:0] amount,
  output logic                   match,
  output logic [ID_BITS-1:0]     tail_id,
  output logic [AMOUNT_BITS-1:0] tail_amount
);

  logic occupied;
  logic is_target;
  logic is_tail;

  assign occupied  = CNTW'(IDX) < count;
  assign is_target = count == CNTW'(IDX);
  assign is_tail   = count == CNTW'(IDX + 1);

  assign tail_id     = is_tail ? id : '0;
  assign tail_amount = is_tail ? amount : '0;

  always_ff @(posedge clk) begin
    unique case (op)
      CELL_SHIFT: begin
        id     <= next_id;
        amount <= next_amount;
      end
      CELL_PUSH: begin
        if (is_target) begin
          id     <= cmd_id;
          amount <= cmd_amount;
        end
      end
      CELL_TRIM: begin
        if (IDX == 0) begin
          amount <= cmd_amount;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (op == CELL_CMP) begin
      match <= occupied && (id == cmd_id);
    end
  end

endmodule

FILE: hw/rtl/capacity_limited_quantity_deque_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capacity_limited_quantity_deque_core
// bounded deque of (id, amount) entries with a running total held against a
// capacity; push, pop front/back, pop count and pop quantity with head split
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  -------   ---------------------  ------------------------------------------
//  request   req_valid / req_ready  req_type, res_id, amount, pop_count
//  response  rsp_valid / rsp_ready  status, has_entry, out_id, out_amount,
//                                   split, last
//  config    cfg_we                 cfg_index, cfg_data
//
//  an item that gives one status or single entry result is accepted, then
//  evaluated against the cell match flags; an item that gives N results then
//  takes N pieces one after another from the head cell (one per cycle while the response register is free)
//  the sequencer takes one item at a time; a result waiting in the response
//  register does not block the accept, only the next emission
//  rst is synchronous: count and total clear, capacity to all ones,
//  tolerance to one; entry cells are not cleared
//
module capacity_limited_quantity_deque_core import clqd_pkg::*; #(
  parameter int DEPTH       = 16,
  parameter int ID_BITS     = 16,
  parameter int AMOUNT_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration writes
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [31:0]            cfg_data,
  // request items
  input  logic                   req_valid,
  output logic                   req_ready,
  input  logic [2:0]             req_type,
  input  logic [ID_BITS-1:0]     res_id,
  input  logic [AMOUNT_BITS-1:0] amount,
  input  logic [4:0]             pop_count,
  // result items
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  output logic [2:0]             status,
  output logic                   has_entry,
  output logic [ID_BITS-1:0]     out_id,
  output logic [AMOUNT_BITS-1:0] out_amount,
  output logic                   split,
  output logic                   last
);

  localparam int CNTW = $clog2(DEPTH + 1);
  localparam int TW   = AMOUNT_BITS + 1;                       // total width
  localparam int CW   = (AMOUNT_BITS + 2 > 34) ? AMOUNT_BITS + 2 : 34;
  localparam int CMPW = (CNTW > 5) ? CNTW : 5;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EVAL = 3'b010,
    S_LOOP = 3'b100
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic [31:0] capacity;
  logic [15:0] tolerance;

  // latched request
  logic [2:0]             req_type_q;
  logic [ID_BITS-1:0]     req_id_q;
  logic [AMOUNT_BITS-1:0] req_amount_q;
  logic [4:0]             req_cnt_q;

  // deque bookkeeping
  logic [CNTW-1:0]        count, count_next;
  logic [TW-1:0]          total, total_next;
  logic [AMOUNT_BITS-1:0] left, left_next;         // quantity still owed
  logic [3:0]             emitted, emitted_next;   // results given so far

  // chain wiring
  cell_op_t               cell_op;
  logic [ID_BITS-1:0]     cmd_id;
  logic [AMOUNT_BITS-1:0] cmd_amount;
  logic [ID_BITS-1:0]     cell_id     [DEPTH];
  logic [AMOUNT_BITS-1:0] cell_amount [DEPTH];
  logic [ID_BITS-1:0]     cell_tid    [DEPTH];
  logic [AMOUNT_BITS-1:0] cell_tamt   [DEPTH];
  logic [DEPTH-1:0]       cell_match;

  logic [ID_BITS-1:0]     tail_id;
  logic [AMOUNT_BITS-1:0] tail_amount;

  // result being produced this cycle
  logic                   emit;
  logic [2:0]             e_status;
  logic                   e_has;
  logic [ID_BITS-1:0]     e_id;
  logic [AMOUNT_BITS-1:0] e_amount;
  logic                   e_split;
  logic                   e_last;

  logic out_free;
  logic over_cap;
  logic duplicate;
  logic full;
  logic cnt_bad;
  logic qty_big;

  // --------------------------------------------------------------------------
  // row of cells, front at cell 0, each shifting from its right neighbor
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ID_BITS-1:0]     nb_id;
    logic [AMOUNT_BITS-1:0] nb_amount;

    if (i < DEPTH - 1) begin : g_nb
      assign nb_id     = cell_id[i+1];
      assign nb_amount = cell_amount[i+1];
    end else begin : g_end
      assign nb_id     = '0;
      assign nb_amount = '0;
    end

    clqd_cell #(
      .IDX         (i),
      .DEPTH       (DEPTH),
      .ID_BITS     (ID_BITS),
      .AMOUNT_BITS (AMOUNT_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .op          (cell_op),
      .cmd_id      (cmd_id),
      .cmd_amount  (cmd_amount),
      .count       (count),
      .next_id     (nb_id),
      .next_amount (nb_amount),
      .id          (cell_id[i]),
      .amount      (cell_amount[i]),
      .match       (cell_match[i]),
      .tail_id     (cell_tid[i]),
      .tail_amount (cell_tamt[i])
    );
  end

  // only the tail cell drives nonzero data, so an or picks it out
  always_comb begin
    tail_id     = '0;
    tail_amount = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_id     = tail_id | cell_tid[i];
      tail_amount = tail_amount | cell_tamt[i];
    end
  end

  // --------------------------------------------------------------------------
  // request checks
  // --------------------------------------------------------------------------
  assign out_free  = !rsp_valid || rsp_ready;
  assign over_cap  = (CW'(req_amount_q) + CW'(total)) > (CW'(capacity) + CW'(tolerance));
  assign duplicate = |cell_match;
  assign full      = count == CNTW'(DEPTH);
  assign cnt_bad   = (CMPW'(req_cnt_q) > CMPW'(count)) || (req_cnt_q > 5'(MAX_RESULTS));
  assign qty_big   = TW'(req_amount_q) > total;

  assign req_ready = state == S_IDLE;

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_next   = state;
    cell_op      = CELL_HOLD;
    cmd_id       = req_id_q;
    cmd_amount   = req_amount_q;
    count_next   = count;
    total_next   = total;
    left_next    = left;
    emitted_next = emitted;
    emit         = 1'b0;
    e_status     = ST_OK;
    e_has        = 1'b0;
    e_id         = '0;
    e_amount     = '0;
    e_split      = 1'b0;
    e_last       = 1'b1;

    unique case (state)
      S_IDLE: begin
        // cells compare their ids against the incoming one on accept
        if (req_valid) begin
          cell_op    = CELL_CMP;
          cmd_id     = res_id;
          state_next = S_EVAL;
        end
      end

      S_EVAL: begin
        if (out_free) begin
          state_next = S_IDLE;
          unique case (req_type_q)
            REQ_PUSH: begin
              emit = 1'b1;
              if (over_cap) begin
                e_status = ST_OVER_CAP;
              end else if (duplicate) begin
                e_status = ST_DUPLICATE;
              end else if (full) begin
                e_status = ST_NO_SLOT;
              end else begin
                cell_op    = CELL_PUSH;
                count_next = count + CNTW'(1);
                total_next = total + TW'(req_amount_q);
              end
            end
            REQ_POP_FRONT, REQ_POP_BACK: begin
              emit = 1'b1;
              if (count == '0) begin
                e_status = ST_EMPTY;
              end else begin
                e_has      = 1'b1;
                count_next = count - CNTW'(1);
                if (req_type_q == REQ_POP_FRONT) begin
                  cell_op  = CELL_SHIFT;
                  e_id     = cell_id[0];
                  e_amount = cell_amount[0];
                end else begin
                  e_id     = tail_id;
                  e_amount = tail_amount;
                end
                total_next = total - TW'(e_amount);
              end
            end
            REQ_POP_COUNT: begin
              if (cnt_bad) begin
                emit     = 1'b1;
                e_status = ST_COUNT_BIG;
              end else if (req_cnt_q == '0) begin
                emit = 1'b1;
              end else begin
                emitted_next = '0;
                state_next   = S_LOOP;
              end
            end
            REQ_POP_QTY: begin
              if (qty_big) begin
                emit     = 1'b1;
                e_status = ST_QTY_BIG;
              end else if (req_amount_q == '0) begin
                emit = 1'b1;
              end else begin
                left_next    = req_amount_q;
                emitted_next = '0;
                state_next   = S_LOOP;
              end
            end
            default: begin
              // unknown request: dropped without a result
            end
          endcase
        end
      end

      S_LOOP: begin
        // one piece a cycle while the response register is free, always from the head cell
        if (out_free) begin
          emit         = 1'b1;
          e_has        = 1'b1;
          e_id         = cell_id[0];
          emitted_next = emitted + 4'd1;
          if (req_type_q == REQ_POP_COUNT) begin
            e_amount   = cell_amount[0];
            cell_op    = CELL_SHIFT;
            count_next = count - CNTW'(1);
            total_next = total - TW'(cell_amount[0]);
            e_last     = (5'(emitted) + 5'd1) == req_cnt_q;
          end else if (cell_amount[0] > left) begin
            // head larger than what is owed: cut it, the rest stays
            e_amount   = left;
            e_split    = 1'b1;
            cell_op    = CELL_TRIM;
            cmd_amount = cell_amount[0] - left;
            total_next = total - TW'(left);
            left_next  = '0;
            e_last     = 1'b1;
          end else begin
            e_amount   = cell_amount[0];
            cell_op    = CELL_SHIFT;
            count_next = count - CNTW'(1);
            total_next = total - TW'(cell_amount[0]);
            left_next  = left - cell_amount[0];
            e_last     = (left_next == '0) || (count == CNTW'(1)) ||
                         (emitted == 4'(MAX_RESULTS - 1));
          end
          if (e_last) begin
            state_next = S_IDLE;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      total     <= '0;
      capacity  <= 32'hFFFF_FFFF;
      tolerance <= 16'd1;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      total <= total_next;
      if (cfg_we) begin
        if (cfg_index == REG_CAPACITY) begin
          capacity <= cfg_data;
        end else begin
          tolerance <= cfg_data[15:0];
        end
      end
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    left    <= left_next;
    emitted <= emitted_next;
    if (req_valid && req_ready) begin
      req_type_q   <= req_type;
      req_id_q     <= res_id;
      req_amount_q <= amount;
      req_cnt_q    <= pop_count;
    end
    if (emit) begin
      status     <= e_status;
      has_entry  <= e_has;
      out_id     <= e_id;
      out_amount <= e_amount;
      split      <= e_split;
      last       <= e_last;
    end
  end

endmodule

FILE: bench/clqd_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clqd_result_checker
// watches the request, response and config ports of the deque core, keeps
// its own copy of the deque and compares every response item in order
// ----------------------------------------------------------------------------
module clqd_result_checker import clqd_pkg::*; #(
  parameter int DEPTH       = 16,
  parameter int ID_BITS     = 16,
  parameter int AMOUNT_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [31:0]            cfg_data,
  input  logic                   req_valid,
  input  logic                   req_ready,
  input  logic [2:0]             req_type,
  input  logic [ID_BITS-1:0]     res_id,
  input  logic [AMOUNT_BITS-1:0] amount,
  input  logic [4:0]             pop_count,
  input  logic                   rsp_valid,
  input  logic                   rsp_ready,
  input  logic [2:0]             status,
  input  logic                   has_entry,
  input  logic [ID_BITS-1:0]     out_id,
  input  logic [AMOUNT_BITS-1:0] out_amount,
  input  logic                   split,
  input  logic                   last,
  output int                     errors,
  output int                     outstanding
);

  localparam int TW = AMOUNT_BITS + 1;

  typedef struct packed {
    logic [2:0]             status;
    logic                   has_entry;
    logic [ID_BITS-1:0]     id;
    logic [AMOUNT_BITS-1:0] amt;
    logic                   split;
    logic                   last;
  } deque_result_t;

  deque_result_t          owed_q[$];
  logic [ID_BITS-1:0]     slot_id [DEPTH];
  logic [AMOUNT_BITS-1:0] slot_amt [DEPTH];
  int                     head;
  int                     fill;
  logic [AMOUNT_BITS:0]   held_total;
  logic [31:0]            cap_reg;
  logic [15:0]            tol_reg;

  function automatic int slot(input int i);
    return (head + i) % DEPTH;
  endfunction

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    errors++;
  endtask

  task automatic owe(input logic [2:0] st, input logic has, input logic [ID_BITS-1:0] id,
                     input logic [AMOUNT_BITS-1:0] amt, input logic sp, input logic lst);
    deque_result_t r;
    r.status    = st;
    r.has_entry = has;
    r.id        = id;
    r.amt       = amt;
    r.split     = sp;
    r.last      = lst;
    owed_q.insert(owed_q.size(), r);
  endtask

  task automatic take_head(output logic [ID_BITS-1:0] id, output logic [AMOUNT_BITS-1:0] amt);
    id         = slot_id[head];
    amt        = slot_amt[head];
    head       = (head + 1) % DEPTH;
    fill       = fill - 1;
    held_total = held_total - TW'(amt);
  endtask

  // apply one accepted request to the deque copy and queue what it owes
  task automatic serve_request(input logic [2:0] kind, input logic [ID_BITS-1:0] id,
                               input logic [AMOUNT_BITS-1:0] amt, input logic [4:0] cnt);
    logic [63:0]            need;
    logic [63:0]            room;
    logic [63:0]            left;
    logic [ID_BITS-1:0]     rid;
    logic [AMOUNT_BITS-1:0] ramt;
    logic                   dup;
    logic                   sp;
    int                     s;
    int                     k;
    case (kind)
      REQ_PUSH: begin
        need = 64'(amt);
        need = need + 64'(held_total);
        room = 64'(cap_reg);
        room = room + 64'(tol_reg);
        dup  = 1'b0;
        for (int i = 0; i < fill; i++) if (slot_id[slot(i)] == id) dup = 1'b1;
        if (need > room) owe(ST_OVER_CAP, 1'b0, '0, '0, 1'b0, 1'b1);
        else if (dup) owe(ST_DUPLICATE, 1'b0, '0, '0, 1'b0, 1'b1);
        else if (fill >= DEPTH) owe(ST_NO_SLOT, 1'b0, '0, '0, 1'b0, 1'b1);
        else begin
          s           = slot(fill);
          slot_id[s]  = id;
          slot_amt[s] = amt;
          fill        = fill + 1;
          held_total  = held_total + TW'(amt);
          owe(ST_OK, 1'b0, '0, '0, 1'b0, 1'b1);
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (fill == 0) owe(ST_EMPTY, 1'b0, '0, '0, 1'b0, 1'b1);
        else begin
          if (kind == REQ_POP_FRONT) take_head(rid, ramt);
          else begin
            s          = slot(fill - 1);
            rid        = slot_id[s];
            ramt       = slot_amt[s];
            fill       = fill - 1;
            held_total = held_total - TW'(ramt);
          end
          owe(ST_OK, 1'b1, rid, ramt, 1'b0, 1'b1);
        end
      end
      REQ_POP_COUNT: begin
        if (int'(cnt) > fill || int'(cnt) > MAX_RESULTS)
          owe(ST_COUNT_BIG, 1'b0, '0, '0, 1'b0, 1'b1);
        else if (cnt == 5'd0) owe(ST_OK, 1'b0, '0, '0, 1'b0, 1'b1);
        else begin
          for (k = 0; k < int'(cnt); k++) begin
            take_head(rid, ramt);
            owe(ST_OK, 1'b1, rid, ramt, 1'b0, k == int'(cnt) - 1);
          end
        end
      end
      REQ_POP_QTY: begin
        left = 64'(amt);
        if (left > 64'(held_total)) owe(ST_QTY_BIG, 1'b0, '0, '0, 1'b0, 1'b1);
        else if (left == 64'd0) owe(ST_OK, 1'b0, '0, '0, 1'b0, 1'b1);
        else begin
          k = 0;
          while (left != 64'd0 && fill > 0 && k < MAX_RESULTS) begin
            if (64'(slot_amt[head]) > left) begin
              // head is bigger than what is still owed: cut a piece off it
              rid            = slot_id[head];
              ramt           = AMOUNT_BITS'(left);
              slot_amt[head] = slot_amt[head] - ramt;
              held_total     = held_total - TW'(ramt);
              left           = 64'd0;
              sp             = 1'b1;
            end else begin
              take_head(rid, ramt);
              left = left - 64'(ramt);
              sp   = 1'b0;
            end
            k++;
            owe(ST_OK, 1'b1, rid, ramt, sp, left == 64'd0 || fill == 0 || k == MAX_RESULTS);
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    deque_result_t w;
    if (rst) begin
      head        = 0;
      fill        = 0;
      held_total  = '0;
      cap_reg     = '1;
      tol_reg     = 16'd1;
      errors      = 0;
      owed_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_CAPACITY) cap_reg = cfg_data;
        else tol_reg = cfg_data[15:0];
      end
      if (req_valid && req_ready) serve_request(req_type, res_id, amount, pop_count);
      if (rsp_valid && rsp_ready) begin
        if (owed_q.size() == 0) report("result item with nothing owed");
        else begin
          w = owed_q[0];
          owed_q.delete(0);
          if (status !== w.status)
            report($sformatf("status got %0d want %0d", status, w.status));
          if (has_entry !== w.has_entry)
            report($sformatf("has_entry got %0d want %0d", has_entry, w.has_entry));
          if (out_id !== w.id)
            report($sformatf("out_id got %h want %h", out_id, w.id));
          if (out_amount !== w.amt)
            report($sformatf("out_amount got %h want %h", out_amount, w.amt));
          if (split !== w.split)
            report($sformatf("split got %0d want %0d", split, w.split));
          if (last !== w.last)
            report($sformatf("last got %0d want %0d", last, w.last));
        end
      end
    end
    outstanding = owed_q.size();
  end

endmodule

FILE: bench/tb_capacity_limited_quantity_deque_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_capacity_limited_quantity_deque_core
// drives directed and random request items into the deque core under
// varying back-pressure and config settings; a checker alongside predicts
// and compares every response item
// ----------------------------------------------------------------------------
module tb_capacity_limited_quantity_deque_core import clqd_pkg::*;;

  localparam int DEPTH       = 16;
  localparam int ID_BITS     = 16;
  localparam int AMOUNT_BITS = 32;
  // hard stop, far beyond the slowest legal run
  localparam int RUN_LIMIT_NS = 4_000_000;
  // length of the long receiver hold-off
  localparam int STALL_CYCLES = 300;

  logic                   clk        = 1'b0;
  logic                   rst        = 1'b1;
  logic                   cfg_we     = 1'b0;
  logic                   cfg_index  = REG_CAPACITY;
  logic [31:0]            cfg_data   = '0;
  logic                   req_valid  = 1'b0;
  logic                   req_ready;
  logic [2:0]             req_type   = REQ_PUSH;
  logic [ID_BITS-1:0]     res_id     = '0;
  logic [AMOUNT_BITS-1:0] amount     = '0;
  logic [4:0]             pop_count  = '0;
  logic                   rsp_valid;
  logic                   rsp_ready  = 1'b0;
  logic [2:0]             status;
  logic                   has_entry;
  logic [ID_BITS-1:0]     out_id;
  logic [AMOUNT_BITS-1:0] out_amount;
  logic                   split;
  logic                   last;

  int errors;
  int outstanding;

  // idle odds in percent, and a counter bumped to request a receiver hold-off
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int stall_gen   = 0;
  // upper end of the usual random push amounts for the current phase
  logic [AMOUNT_BITS-1:0] amt_span = 32'h0003_0000;

  always #2 clk = ~clk;

  capacity_limited_quantity_deque_core #(
    .DEPTH      (DEPTH),
    .ID_BITS    (ID_BITS),
    .AMOUNT_BITS(AMOUNT_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_type  (req_type),
    .res_id    (res_id),
    .amount    (amount),
    .pop_count (pop_count),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .status    (status),
    .has_entry (has_entry),
    .out_id    (out_id),
    .out_amount(out_amount),
    .split     (split),
    .last      (last)
  );

  clqd_result_checker #(
    .DEPTH      (DEPTH),
    .ID_BITS    (ID_BITS),
    .AMOUNT_BITS(AMOUNT_BITS)
  ) u_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req_type   (req_type),
    .res_id     (res_id),
    .amount     (amount),
    .pop_count  (pop_count),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .status     (status),
    .has_entry  (has_entry),
    .out_id     (out_id),
    .out_amount (out_amount),
    .split      (split),
    .last       (last),
    .errors     (errors),
    .outstanding(outstanding)
  );

  // response side: random ready, or a long hold-off counted here
  initial begin : receiver
    int hold;
    int seen;
    hold = 0;
    seen = 0;
    forever begin
      @(negedge clk);
      if (stall_gen != seen) begin
        hold = STALL_CYCLES;
        seen = stall_gen;
      end
      if (hold > 0) begin
        hold--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // offer one item, with random gaps ahead of it, and hold it until accepted
  task automatic send_item(input logic [2:0] kind, input logic [ID_BITS-1:0] id,
                           input logic [AMOUNT_BITS-1:0] amt, input logic [4:0] cnt);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req_type  <= kind;
    res_id    <= id;
    amount    <= amt;
    pop_count <= cnt;
    do @(posedge clk); while (!req_ready);
  endtask

  // stop offering and wait until every owed result item has come back;
  // unknown request codes owe nothing but still occupy the core briefly
  task automatic settle();
    @(negedge clk);
    req_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // one random item, mostly well-formed traffic with a few unknown codes
  task automatic random_item(output bit counted);
    int                     r;
    int                     m;
    logic [2:0]             kind;
    logic [ID_BITS-1:0]     id;
    logic [AMOUNT_BITS-1:0] amt;
    logic [4:0]             cnt;
    r       = $urandom_range(99);
    m       = $urandom_range(9);
    counted = 1'b1;
    // small id pool so duplicates happen often
    id  = ($urandom_range(9) < 7) ? ID_BITS'($urandom_range(23)) : ID_BITS'($urandom);
    cnt = ($urandom_range(4) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(4));
    if (r < 45) begin
      kind = REQ_PUSH;
      if (m == 0) amt = '0;
      else if (m == 1) amt = $urandom;
      else if (m == 2) amt = '1 - $urandom_range(255);
      else amt = $urandom_range(amt_span);
    end else begin
      if (r < 55) kind = REQ_POP_FRONT;
      else if (r < 62) kind = REQ_POP_BACK;
      else if (r < 75) kind = REQ_POP_COUNT;
      else if (r < 95) kind = REQ_POP_QTY;
      else begin
        kind    = REQ_POP_QTY + 3'($urandom_range(1, 3));
        counted = 1'b0;
      end
      if (m == 0) amt = '0;
      else if (m == 1) amt = $urandom;
      else amt = $urandom_range(amt_span * 3);
    end
    send_item(kind, id, amt, cnt);
  endtask

  initial begin : stimulus
    int sent;
    int quota;
    bit counted;

    // synchronous reset held from time zero, released on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    tx_idle_pct = 30;
    rx_idle_pct = 79;

    // ---- directed, reset config: capacity all ones, tolerance one ----
    // empty deque cases
    send_item(REQ_POP_FRONT, '0, '0, '0);
    send_item(REQ_POP_BACK,  '0, '0, '0);
    send_item(REQ_POP_COUNT, '0, '0, 5'd0);
    send_item(REQ_POP_COUNT, '0, '0, 5'd1);
    send_item(REQ_POP_QTY,   '0, '0, '0);
    send_item(REQ_POP_QTY,   '0, 32'd1, '0);
    // largest amount, then a push that lands exactly on capacity plus slack
    send_item(REQ_PUSH, '1, '1, '1);
    send_item(REQ_PUSH, '0, 32'd1, '0);
    send_item(REQ_PUSH, 16'd1, 32'd1, '0);
    // zero amount with a taken id: capacity passes, duplicate refuses
    send_item(REQ_PUSH, '1, '0, '0);
    // unknown codes are dropped without a result
    send_item(REQ_POP_QTY + 3'd1, '1, '1, '1);
    send_item(REQ_POP_QTY + 3'd2, '0, '0, '0);
    send_item(REQ_POP_QTY + 3'd3, '1, '0, '1);
    // quantity equal to the head entry takes it whole
    send_item(REQ_POP_QTY, '0, '1, '0);
    // zero-amount entry gets swept while quantity is owed, then a head cut
    send_item(REQ_PUSH, 16'd2, '0, '0);
    send_item(REQ_PUSH, 16'd3, 32'h0001_8000, '0);
    send_item(REQ_POP_QTY, '0, 32'h0000_8000, '0);
    send_item(REQ_POP_BACK, '0, '0, '0);

    // tight capacity, no slack, then capacity lowered under the held total
    settle();
    write_reg(REG_CAPACITY, 32'h0002_0000);
    write_reg(REG_TOLERANCE, 32'd0);
    send_item(REQ_PUSH, 16'd4, 32'h0003_0000, '0);
    send_item(REQ_PUSH, 16'd4, 32'h0002_0000, '0);
    settle();
    write_reg(REG_CAPACITY, 32'h0001_0000);
    send_item(REQ_PUSH, 16'd5, '0, '0);
    send_item(REQ_POP_FRONT, '0, '0, '0);

    // ---- pressure: receiver held off while the deque is filled past full ----
    settle();
    write_reg(REG_CAPACITY, '1);
    write_reg(REG_TOLERANCE, 32'hFFFF);
    tx_idle_pct = 0;
    stall_gen++;
    for (int i = 0; i < DEPTH; i++)
      send_item(REQ_PUSH, ID_BITS'(16'h0100 + i), AMOUNT_BITS'(32'h1000 * (i + 1)), '0);
    send_item(REQ_PUSH, 16'h0100, 32'd7, '0);
    send_item(REQ_PUSH, 16'h0200, 32'd7, '0);
    // count above the limit, above the held count, then drain all at once
    send_item(REQ_POP_COUNT, '0, '0, 5'd31);
    send_item(REQ_POP_COUNT, '0, '0, 5'd17);
    send_item(REQ_POP_COUNT, '0, '0, 5'd16);

    // ---- random phases with different config and idle pattern ----
    for (int p = 0; p < 3; p++) begin
      settle();
      case (p)
        0: begin
          write_reg(REG_CAPACITY, 32'h000C_0000);
          write_reg(REG_TOLERANCE, 32'h8000);
          amt_span    = 32'h0003_0000;
          tx_idle_pct = 30;
          rx_idle_pct = 79;
          quota       = 40;
        end
        1: begin
          // capacity floor with maximum slack; small amounts keep pushes alive
          write_reg(REG_CAPACITY, 32'd0);
          write_reg(REG_TOLERANCE, 32'hFFFF);
          amt_span    = 32'h0000_3000;
          tx_idle_pct = 79;
          rx_idle_pct = 30;
          quota       = 40;
        end
        default: begin
          write_reg(REG_CAPACITY, '1);
          write_reg(REG_TOLERANCE, 32'd0);
          amt_span    = 32'h0004_0000;
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          quota       = 35;
        end
      endcase
      sent = 0;
      while (sent < quota) begin
        random_item(counted);
        if (counted) sent++;
      end
    end

    // drain, let the core go quiet, then give the verdict
    settle();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog, also catches owed result items that never arrive
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/clqd_pkg.sv
hw/rtl/clqd_cell.sv
hw/rtl/capacity_limited_quantity_deque_core.sv
bench/clqd_result_checker.sv
bench/tb_capacity_limited_quantity_deque_core.sv
